/* src/bounded_sequence_store_core_assert.svh */
// Assertion macros used by the checker file of the sequence store.
`ifndef BOUNDED_SEQUENCE_STORE_CORE_ASSERT_SVH
`define BOUNDED_SEQUENCE_STORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequence store assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence store assertion failed");

`endif

/* src/bss_pkg.sv */
`timescale 1ns / 1ps

package bss_pkg;

   typedef enum logic [2:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_INSERT     = 3'd4,
      FUNC_SEARCH     = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_BADPOS = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic insert;
      logic drop_head;
      logic capture;
      logic shift;
   } cell_cmd_type;

endpackage

/* src/bss_cell.sv */
`timescale 1ns / 1ps

module bss_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bss_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]      at,
   input  logic [CNT_W-1:0]      count,
   input  logic [DATA_WIDTH-1:0] new_data,
   input  logic [DATA_WIDTH-1:0] lower_data,
   input  logic [DATA_WIDTH-1:0] upper_data,
   input  logic                  upper_match,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  match
);
   import bss_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  match_ff;
   logic                  match_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.drop_head) begin
         data_in = upper_data;
      end else if (cmd.insert) begin
         if (at == MY_IDX) begin
            data_in = new_data;
         end else if (at < MY_IDX) begin
            data_in = lower_data;
         end
      end
   end

   always_comb begin
      match_in = match_ff;
      if (cmd.capture) begin
         match_in = (MY_CNT < count) && (data_ff == new_data);
      end else if (cmd.shift) begin
         match_in = upper_match;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

/* src/bounded_sequence_store_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Transfer when     Ports
// request   in         start && !busy   req_func, req_value, req_position
// response  out        rsp_valid        rsp_status, rsp_found, rsp_match_index,
//                                       rsp_entry_count
//
// Push, pop and insert shift the affected cells in parallel and respond in the cycle after the transfer.
// A search of a non-empty store captures a match bit in every cell and then shifts the bits
// toward cell zero, one cell per cycle, until a match or the last entry; busy is high meanwhile.
// A synchronous reset empties the store; the entries themselves are not cleared.
// The response is held for one cycle only, since the receiver cannot stall.
module bounded_sequence_store_core #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_position,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [3:0]  rsp_match_index,
   output logic [4:0]  rsp_entry_count
);
   import bss_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = CNT_W + 5;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type             state_ff;
   state_type             state_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [IDX_W-1:0]      scan_ff;
   logic [IDX_W-1:0]      scan_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic                  rsp_found_ff;
   logic                  rsp_found_in;
   logic [3:0]            rsp_match_index_ff;
   logic [3:0]            rsp_match_index_in;
   logic [4:0]            rsp_entry_count_ff;
   logic [4:0]            rsp_entry_count_in;

   cell_cmd_type          cmd;
   logic [IDX_W-1:0]      at;
   logic [63:0]           value_wide;
   logic [DATA_WIDTH-1:0] new_data;
   logic                  is_full;
   logic                  is_empty;

   logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
   logic                  cell_match [CAPACITY];

   assign value_wide = {32'b0, req_value};
   assign new_data   = value_wide[DATA_WIDTH-1:0];
   assign is_full    = (count_ff == CAP_CNT);
   assign is_empty   = (count_ff == '0);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_data;
      logic [DATA_WIDTH-1:0] upper_data;
      logic                  upper_match;

      if (i == 0) begin : g_first
         assign lower_data = '0;
      end else begin : g_inner_low
         assign lower_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign upper_data  = '0;
         assign upper_match = 1'b0;
      end else begin : g_inner_high
         assign upper_data  = cell_data[i+1];
         assign upper_match = cell_match[i+1];
      end

      bss_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .at          (at),
         .count       (count_ff),
         .new_data    (new_data),
         .lower_data  (lower_data),
         .upper_data  (upper_data),
         .upper_match (upper_match),
         .data        (cell_data[i]),
         .match       (cell_match[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff      <= rsp_status_in;
      rsp_found_ff       <= rsp_found_in;
      rsp_match_index_ff <= rsp_match_index_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      scan_in            = scan_ff;
      cmd                = '0;
      at                 = '0;
      rsp_valid_in       = 1'b0;
      rsp_status_in      = rsp_status_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_match_index_in = rsp_match_index_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = STATUS_OK;
               rsp_found_in       = 1'b0;
               rsp_match_index_in = '0;
               unique case (func_type'(req_func))
                  FUNC_PUSH_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  FUNC_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                        at         = count_ff[IDX_W-1:0];
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  FUNC_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cmd.drop_head = 1'b1;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  FUNC_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  FUNC_INSERT: begin
                     if (CMP_W'(req_position) > CMP_W'(count_ff)) begin
                        rsp_status_in = STATUS_BADPOS;
                     end else if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                        at         = IDX_W'(req_position);
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  FUNC_SEARCH: begin
                     if (!is_empty) begin
                        rsp_valid_in = 1'b0;
                        cmd.capture  = 1'b1;
                        scan_in      = '0;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rsp_status_in = STATUS_OK;
            if (cell_match[0]) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b1;
               rsp_match_index_in = 4'(scan_ff);
               state_in           = ST_IDLE;
            end else if ((CNT_W'(scan_ff) + 1'b1) == count_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b0;
               rsp_match_index_in = '0;
               state_in           = ST_IDLE;
            end else begin
               cmd.shift = 1'b1;
               scan_in   = scan_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_entry_count_in = 5'(count_in);
   end

   assign busy            = (state_ff == ST_SCAN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_match_index_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule

/* src/bss_checker.sv */
`timescale 1ns / 1ps
`include "bounded_sequence_store_core_assert.svh"

module bss_checker #(
   parameter int CAPACITY = 16
) (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_func,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic       rsp_found,
   input logic [4:0] rsp_entry_count
);
   import bss_pkg::*;

   localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

   `BSS_ASSERT_NOW(a_found_is_ok, clock, reset, rsp_valid && rsp_found, rsp_status == STATUS_OK)
   `BSS_ASSERT_NOW(a_empty_count, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), rsp_entry_count == 5'd0)
   `BSS_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), rsp_entry_count == CAP_LOW)
   `BSS_ASSERT_NEXT(a_quick_reply, clock, reset, start && !busy && (req_func != FUNC_SEARCH), rsp_valid && !busy)

endmodule

bind bounded_sequence_store_core bss_checker #(.CAPACITY(CAPACITY)) u_bss_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import bss_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int WORD_WIDTH = 32;
   localparam int RANDOM_REQUESTS = 600;
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [2:0] FUNC_UNUSED_SIX = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_SEVEN = 3'd7;

   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_MINUS_ONE = 32'hFFFF_FFFF;
   localparam logic [31:0] WORD_ABSENT = 32'd12345;

   typedef struct {
      logic [2:0]  func;
      logic [31:0] value;
      logic [4:0]  position;
      int          idle_pct;
   } request_type;

   typedef struct packed {
      status_type status;
      logic       found;
      logic [3:0] match_index;
      logic [4:0] entry_count;
   } reply_type;

   typedef struct {
      logic [WORD_WIDTH-1:0] word [LIST_DEPTH];
      int                    fill;
   } list_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = '0;
   logic [31:0] req_value = '0;
   logic [4:0]  req_position = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [3:0]  rsp_match_index;
   logic [4:0]  rsp_entry_count;

   request_type queued_requests[$];
   reply_type   awaited_replies[$];
   request_type active_req;
   list_type    shadow_list;
   list_type    planned_list;

   int failures = 0;
   int cycle_count = 0;
   int func_seen [8];
   int status_seen [4];
   int search_hits = 0;
   int deepest_fill = 0;

   bounded_sequence_store_core #(
      .CAPACITY   (LIST_DEPTH),
      .DATA_WIDTH (WORD_WIDTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Applies one request to a list and returns the reply that the store must give.
   function automatic reply_type update_list(inout list_type lst, input request_type rq);
      reply_type rs;
      int        slot;
      int        i;
      rs = '{status: STATUS_OK, found: 1'b0, match_index: '0, entry_count: '0};
      slot = -1;
      case (rq.func)
         FUNC_PUSH_FRONT: begin
            if (lst.fill >= LIST_DEPTH) rs.status = STATUS_FULL;
            else slot = 0;
         end
         FUNC_PUSH_BACK: begin
            if (lst.fill >= LIST_DEPTH) rs.status = STATUS_FULL;
            else slot = lst.fill;
         end
         FUNC_POP_FRONT: begin
            if (lst.fill == 0) begin
               rs.status = STATUS_EMPTY;
            end else begin
               for (i = 0; i + 1 < lst.fill; i++) lst.word[i] = lst.word[i + 1];
               lst.fill--;
            end
         end
         FUNC_POP_BACK: begin
            if (lst.fill == 0) rs.status = STATUS_EMPTY;
            else lst.fill--;
         end
         FUNC_INSERT: begin
            if (int'(rq.position) > lst.fill) rs.status = STATUS_BADPOS;
            else if (lst.fill >= LIST_DEPTH) rs.status = STATUS_FULL;
            else slot = rq.position;
         end
         FUNC_SEARCH: begin
            for (i = 0; i < lst.fill && !rs.found; i++) begin
               if (lst.word[i] == rq.value[WORD_WIDTH-1:0]) begin
                  rs.found = 1'b1;
                  rs.match_index = i[3:0];
               end
            end
         end
         default: begin
         end
      endcase
      if (slot >= 0) begin
         for (i = lst.fill; i > slot; i--) lst.word[i] = lst.word[i - 1];
         lst.word[slot] = rq.value[WORD_WIDTH-1:0];
         lst.fill++;
      end
      rs.entry_count = lst.fill[4:0];
      return rs;
   endfunction

   task automatic plan_request(input logic [2:0] func, input logic [31:0] value,
                               input logic [4:0] position, input int idle_pct);
      request_type rq;
      reply_type   ignored;
      rq = '{func: func, value: value, position: position, idle_pct: idle_pct};
      ignored = update_list(planned_list, rq);
      queued_requests.insert(queued_requests.size(), rq);
   endtask

   // Extremes, small values and random words; the small values make duplicate entries likely.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return WORD_MINUS_ONE;
         3, 4: return 32'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   task automatic plan_random_request(inout bit growing, input int idle_pct);
      int          roll;
      int          fill;
      logic [31:0] key;
      fill = planned_list.fill;
      if (fill == LIST_DEPTH) growing = 1'b0;
      if (fill == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if ((roll < 50 && growing) || (roll >= 50 && roll < 70 && !growing)) begin
         case ($urandom_range(2))
            0: plan_request(FUNC_PUSH_FRONT, pick_word(), 5'($urandom), idle_pct);
            1: plan_request(FUNC_PUSH_BACK, pick_word(), 5'($urandom), idle_pct);
            default: plan_request(FUNC_INSERT, pick_word(), 5'($urandom_range(fill)),
                                  idle_pct);
         endcase
      end else if (roll < 70) begin
         if ($urandom_range(1) == 0) plan_request(FUNC_POP_FRONT, $urandom, 5'($urandom),
                                                  idle_pct);
         else plan_request(FUNC_POP_BACK, $urandom, 5'($urandom), idle_pct);
      end else if (roll < 90) begin
         if (fill > 0 && $urandom_range(3) != 0) key = planned_list.word[$urandom_range(fill - 1)];
         else key = pick_word();
         plan_request(FUNC_SEARCH, key, 5'($urandom), idle_pct);
      end else begin
         case ($urandom_range(3))
            0: plan_request($urandom_range(1) ? FUNC_UNUSED_SIX : FUNC_UNUSED_SEVEN,
                            $urandom, 5'($urandom), idle_pct);
            1: plan_request(FUNC_INSERT, pick_word(), 5'($urandom_range(31, fill + 1)),
                            idle_pct);
            default: plan_request(3'($urandom_range(7)), $urandom, 5'($urandom), idle_pct);
         endcase
      end
   endtask

   always @(posedge clock) begin : drive_requests
      logic      handed_over;
      reply_type next_reply;
      handed_over = start && !busy;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (handed_over) begin
            next_reply = update_list(shadow_list, active_req);
            awaited_replies.insert(awaited_replies.size(), next_reply);
            func_seen[active_req.func]++;
            if (shadow_list.fill > deepest_fill) deepest_fill = shadow_list.fill;
         end
         if (!start || handed_over) begin
            if (queued_requests.size() > 0 &&
                $urandom_range(99) >= queued_requests[0].idle_pct) begin
               active_req = queued_requests[0];
               queued_requests.delete(0);
               start <= 1'b1;
               req_func <= active_req.func;
               req_value <= active_req.value;
               req_position <= active_req.position;
            end else begin
               start <= 1'b0;
               req_func <= 3'($urandom);
               req_value <= $urandom;
               req_position <= 5'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_valid) begin
         if (awaited_replies.size() == 0) begin
            $error("response with no transfer outstanding: status %0d, count %0d",
                   rsp_status, rsp_entry_count);
            failures++;
         end else begin
            want = awaited_replies[0];
            awaited_replies.delete(0);
            status_seen[want.status]++;
            if (want.found) search_hits++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               failures++;
            end
            if (rsp_match_index !== want.match_index) begin
               $error("match_index: expected %0d, actual %0d", want.match_index,
                      rsp_match_index);
               failures++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count,
                      rsp_entry_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : run_test
      bit growing;
      int n;
      int pct;
      growing = 1'b1;
      shadow_list.fill = 0;
      planned_list.fill = 0;

      plan_request(FUNC_SEARCH, 32'd0, 5'd0, 37);
      plan_request(FUNC_POP_FRONT, 32'd0, 5'd0, 37);
      plan_request(FUNC_POP_BACK, WORD_MINUS_ONE, 5'd31, 37);
      plan_request(FUNC_UNUSED_SIX, WORD_MAX, 5'd0, 37);
      plan_request(FUNC_UNUSED_SEVEN, WORD_MINUS_ONE, 5'd31, 37);
      plan_request(FUNC_INSERT, WORD_MAX, 5'd1, 37);
      plan_request(FUNC_INSERT, WORD_MIN, 5'd0, 37);
      plan_request(FUNC_POP_FRONT, 32'd0, 5'd0, 37);
      plan_request(FUNC_SEARCH, WORD_MIN, 5'd0, 37);
      plan_request(FUNC_INSERT, WORD_MIN, 5'd0, 37);
      plan_request(FUNC_PUSH_FRONT, WORD_MAX, 5'd0, 37);
      plan_request(FUNC_PUSH_BACK, WORD_MINUS_ONE, 5'd0, 37);
      plan_request(FUNC_INSERT, 32'd0, 5'd3, 37);
      plan_request(FUNC_INSERT, 32'd5, 5'd2, 37);
      plan_request(FUNC_INSERT, 32'd7, 5'd31, 37);
      plan_request(FUNC_PUSH_BACK, 32'd5, 5'd0, 37);
      plan_request(FUNC_SEARCH, 32'd5, 5'd0, 37);
      plan_request(FUNC_SEARCH, 32'd0, 5'd0, 37);
      plan_request(FUNC_SEARCH, WORD_MAX, 5'd0, 37);
      plan_request(FUNC_SEARCH, WORD_ABSENT, 5'd0, 37);
      plan_request(FUNC_POP_FRONT, 32'd0, 5'd0, 37);
      plan_request(FUNC_POP_BACK, 32'd0, 5'd0, 37);
      plan_request(FUNC_SEARCH, WORD_MINUS_ONE, 5'd0, 37);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         pct = (n < RANDOM_REQUESTS / 3) ? 37 : (n < 2 * RANDOM_REQUESTS / 3) ? 83 : 0;
         plan_random_request(growing, pct);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || start || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Transfers: %0d push, %0d pop, %0d insert, %0d search (%0d hits), %0d unused code",
               func_seen[FUNC_PUSH_FRONT] + func_seen[FUNC_PUSH_BACK],
               func_seen[FUNC_POP_FRONT] + func_seen[FUNC_POP_BACK],
               func_seen[FUNC_INSERT], func_seen[FUNC_SEARCH], search_hits,
               func_seen[FUNC_UNUSED_SIX] + func_seen[FUNC_UNUSED_SEVEN]);
      $display("Replies: %0d ok, %0d empty, %0d full, %0d bad position; deepest fill %0d of %0d",
               status_seen[STATUS_OK], status_seen[STATUS_EMPTY], status_seen[STATUS_FULL],
               status_seen[STATUS_BADPOS], deepest_fill, LIST_DEPTH);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* bounded_sequence_store_core.f */
+incdir+src
src/bss_pkg.sv
src/bss_cell.sv
src/bounded_sequence_store_core.sv
src/bss_checker.sv
verif/tb_top.sv
